@@ sv/lcdfw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the character-to-segment table for the
// segment LCD frame writer. No dependencies.
package lcdfw_pkg;

  localparam int unsigned Digits         = 6;
  localparam int unsigned DefClearFrames = 16;
  localparam int unsigned FrameW         = 17;
  localparam int unsigned LenW           = 5;
  localparam int unsigned AddrW          = 6;
  localparam int unsigned ByteIdxW       = $clog2(Digits);

  localparam logic [LenW-1:0] LenCmd  = LenW'(12);
  localparam logic [LenW-1:0] LenData = LenW'(17);

  localparam logic [3:0] CmdPrefix  = 4'b1000;
  localparam logic [2:0] DataPrefix = 3'b101;

  typedef enum logic [2:0] {
    MODE_CMD     = 3'd0,
    MODE_CHAR    = 3'd1,
    MODE_BATT    = 3'd2,
    MODE_DP      = 3'd3,
    MODE_REFRESH = 3'd4,
    MODE_CLEAR   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    JOB_CMD     = 2'd0,
    JOB_REFRESH = 2'd1,
    JOB_CLEAR   = 2'd2
  } job_kind_e;

  // One unit of work for the frame generator; refresh jobs carry a copy
  // of the buffer taken when the item was accepted.
  typedef struct packed {
    job_kind_e                 kind;
    logic [7:0]                code;
    logic [Digits-1:0][7:0]    bytes;
  } job_t;

  function automatic logic [6:0] seg_pattern(input logic [7:0] ch);
    logic [6:0] pat;
    case (ch)
      8'h2A: pat = 7'h33; // '*'
      8'h7C: pat = 7'h05; // '|'
      8'h2D: pat = 7'h02; // '-'
      8'h5F: pat = 7'h08; // '_'
      8'h30: pat = 7'h7D;
      8'h31: pat = 7'h60;
      8'h32: pat = 7'h3E;
      8'h33: pat = 7'h7A;
      8'h34: pat = 7'h63;
      8'h35: pat = 7'h5B;
      8'h36: pat = 7'h5F;
      8'h37: pat = 7'h70;
      8'h38: pat = 7'h7F;
      8'h39: pat = 7'h7B;
      8'h41: pat = 7'h77; // 'A'
      8'h62: pat = 7'h4F; // 'b'
      8'h63: pat = 7'h0E; // 'c'
      8'h43: pat = 7'h1D; // 'C'
      8'h64: pat = 7'h6E; // 'd'
      8'h65: pat = 7'h0E; // 'e'
      8'h45: pat = 7'h1F; // 'E'
      8'h66: pat = 7'h07; // 'f'
      8'h46: pat = 7'h17; // 'F'
      8'h47: pat = 7'h5F; // 'G'
      8'h68: pat = 7'h47; // 'h'
      8'h48: pat = 7'h67; // 'H'
      8'h69: pat = 7'h40; // 'i'
      8'h49: pat = 7'h60; // 'I'
      8'h4A: pat = 7'h68; // 'J'
      8'h6C: pat = 7'h60; // 'l'
      8'h4C: pat = 7'h0D; // 'L'
      8'h4D: pat = 7'h75; // 'M'
      8'h6E: pat = 7'h46; // 'n'
      8'h6F: pat = 7'h4E; // 'o'
      8'h4F: pat = 7'h7D; // 'O'
      8'h50: pat = 7'h37; // 'P'
      8'h72: pat = 7'h06; // 'r'
      8'h53: pat = 7'h5B; // 'S'
      8'h74: pat = 7'h0F; // 't'
      8'h75: pat = 7'h4C; // 'u'
      8'h55: pat = 7'h6D; // 'U'
      8'h59: pat = 7'h6B; // 'Y'
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

@@ sv/segment_lcd_frame_writer.sv @@
`timescale 1ns / 1ps
// Segment LCD frame writer top level: front end, job queue, frame generator.
// A frame producing item passes the job queue and the job register, then its
// frames enter the result register, one per cycle while it is empty or popped;
// the generator fetches each job from the two-entry job queue in its idle state.
// Buffer updates take effect in the accept cycle; reset clears the buffer and
// empties the job queue and the result register.
module segment_lcd_frame_writer #(
  parameter int unsigned ClearFrames = lcdfw_pkg::DefClearFrames
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [2:0]                   mode_i,
  input  logic [7:0]                   command_code_i,
  input  logic [2:0]                   digit_position_i,
  input  logic [7:0]                   character_code_i,
  input  logic [1:0]                   battery_level_i,
  input  logic [1:0]                   decimal_digits_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [lcdfw_pkg::FrameW-1:0] frame_bits_o,
  output logic [lcdfw_pkg::LenW-1:0]   frame_length_o,
  output logic                         last_o
);
  import lcdfw_pkg::*;

  job_t job_in, job_out;
  logic job_push, job_pop, jobq_empty;

  lcdfw_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .mode_i           (mode_i),
    .command_code_i   (command_code_i),
    .digit_position_i (digit_position_i),
    .character_code_i (character_code_i),
    .battery_level_i  (battery_level_i),
    .decimal_digits_i (decimal_digits_i),
    .jobq_full_i      (full),
    .job_push_o       (job_push),
    .job_o            (job_in)
  );

  lcdfw_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .empty_o (jobq_empty),
    .data_o  (job_out)
  );

  lcdfw_back #(
    .ClearFrames (ClearFrames)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .jobq_empty_i   (jobq_empty),
    .job_i          (job_out),
    .jobq_pop_o     (job_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .frame_bits_o   (frame_bits_o),
    .frame_length_o (frame_length_o),
    .last_o         (last_o)
  );

endmodule

@@ sv/lcdfw_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts items, keeps the segment buffer and turns frame
// producing items into jobs. Depends on lcdfw_pkg.
module lcdfw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [2:0]          mode_i,
  input  logic [7:0]          command_code_i,
  input  logic [2:0]          digit_position_i,
  input  logic [7:0]          character_code_i,
  input  logic [1:0]          battery_level_i,
  input  logic [1:0]          decimal_digits_i,
  input  logic                jobq_full_i,
  output logic                job_push_o,
  output lcdfw_pkg::job_t     job_o
);
  import lcdfw_pkg::*;

  logic [Digits-1:0][7:0] seg_q, seg_d;
  logic                   accept;

  assign accept = push_i && !jobq_full_i;

  always_comb begin
    seg_d      = seg_q;
    job_push_o = 1'b0;
    job_o.kind = JOB_CMD;
    job_o.code = command_code_i;
    if (accept) begin
      case (mode_i)
        MODE_CMD: begin
          job_push_o = 1'b1;
        end
        MODE_CHAR: begin
          if (digit_position_i < 3'(Digits)) begin
            seg_d[digit_position_i][6:0] = seg_pattern(character_code_i);
          end
        end
        MODE_BATT: begin
          seg_d[0][7] = (battery_level_i == 2'd3);
          seg_d[1][7] = (battery_level_i >= 2'd2);
          seg_d[2][7] = (battery_level_i != 2'd0);
          job_push_o  = 1'b1;
          job_o.kind  = JOB_REFRESH;
        end
        MODE_DP: begin
          // d digits after the point lights bit 7 of byte 6-d
          seg_d[3][7] = (decimal_digits_i == 2'd3);
          seg_d[4][7] = (decimal_digits_i == 2'd2);
          seg_d[5][7] = (decimal_digits_i == 2'd1);
        end
        MODE_REFRESH: begin
          job_push_o = 1'b1;
          job_o.kind = JOB_REFRESH;
        end
        MODE_CLEAR: begin
          job_push_o = 1'b1;
          job_o.kind = JOB_CLEAR;
        end
        default: ;
      endcase
    end
    job_o.bytes = seg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= '0;
    end else begin
      seg_q <= seg_d;
    end
  end

endmodule

@@ sv/lcdfw_jobq.sv @@
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the frame generator.
// Depends on lcdfw_pkg.
module lcdfw_jobq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lcdfw_pkg::job_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output lcdfw_pkg::job_t data_o
);
  import lcdfw_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2) else $error("job queue count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("job queue pointers disagree with count");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |=> full_o) else $error("job queue lost an entry");
`endif

endmodule

@@ sv/lcdfw_back.sv @@
`timescale 1ns / 1ps
// Frame generator: takes jobs from the queue and emits one frame per cycle
// into the result register while it is empty or popped. Depends on lcdfw_pkg.
module lcdfw_back #(
  parameter int unsigned ClearFrames = lcdfw_pkg::DefClearFrames
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           jobq_empty_i,
  input  lcdfw_pkg::job_t                job_i,
  output logic                           jobq_pop_o,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [lcdfw_pkg::FrameW-1:0]   frame_bits_o,
  output logic [lcdfw_pkg::LenW-1:0]     frame_length_o,
  output logic                           last_o
);
  import lcdfw_pkg::*;

  localparam int unsigned MaxFrames = (ClearFrames > Digits) ? ClearFrames : Digits;
  localparam int unsigned CntW      = $clog2(MaxFrames);
  localparam logic [CntW-1:0] LastRefresh = CntW'(Digits - 1);
  localparam logic [CntW-1:0] LastClear   = CntW'(ClearFrames - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e              state_q, state_d;
  job_t                job_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                ovalid_q, ovalid_d;
  logic [FrameW-1:0]   frame_q, frame_d;
  logic [LenW-1:0]     len_q, len_d;
  logic                last_q, last_d;
  logic                load;
  logic [AddrW-1:0]    addr;
  logic [ByteIdxW-1:0] byte_idx;

  assign jobq_pop_o = (state_q == ST_IDLE) && !jobq_empty_i;
  assign load       = (state_q == ST_RUN) && (!ovalid_q || pop_i);
  assign addr       = AddrW'({cnt_q, 1'b0});
  // refresh frame k carries buffer byte Digits-1-k
  assign byte_idx   = ByteIdxW'(Digits - 1) - cnt_q[ByteIdxW-1:0];

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !pop_i;
    frame_d  = frame_q;
    len_d    = len_q;
    last_d   = last_q;
    case (state_q)
      ST_IDLE: begin
        if (jobq_pop_o) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        if (load) begin
          ovalid_d = 1'b1;
          case (job_q.kind)
            JOB_CMD: begin
              frame_d = FrameW'({CmdPrefix, job_q.code});
              len_d   = LenCmd;
              last_d  = 1'b1;
            end
            JOB_REFRESH: begin
              frame_d = {DataPrefix, addr, job_q.bytes[byte_idx]};
              len_d   = LenData;
              last_d  = (cnt_q == LastRefresh);
            end
            default: begin
              frame_d = {DataPrefix, addr, 8'h00};
              len_d   = LenData;
              last_d  = (cnt_q == LastClear);
            end
          endcase
          if (last_d) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (jobq_pop_o) begin
      job_q <= job_i;
    end
    if (load) begin
      frame_q <= frame_d;
      len_q   <= len_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign empty_o        = !ovalid_q;
  assign frame_bits_o   = frame_q;
  assign frame_length_o = len_q;
  assign last_o         = last_q;

`ifndef ASSERT_OFF
  a_len_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (len_q == LenCmd || len_q == LenData))
    else $error("illegal frame length");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && job_q.kind == JOB_REFRESH) |-> (cnt_q <= LastRefresh))
    else $error("refresh counter overran");
  a_last_ends_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_d) |=> (state_q == ST_IDLE && ovalid_q && last_q))
    else $error("job did not end on its last frame");
`endif

endmodule
